// ===== src/hmte_pkg.sv =====
// shared constants, types and pattern-match functions for the html text extractor
// no dependencies; imported by html_markup_text_extractor
package hmte_pkg;

	localparam int unsigned NestDepthDef = 16;
	localparam int unsigned TagKeep      = 8;
	localparam int unsigned EntKeep      = 6;
	localparam int unsigned OutDepth     = 4;
	localparam logic [2:0]  EntLong      = 3'd7;

	localparam logic [7:0] ChLt      = 8'h3C;
	localparam logic [7:0] ChGt      = 8'h3E;
	localparam logic [7:0] ChAmp     = 8'h26;
	localparam logic [7:0] ChSemi    = 8'h3B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChNewline = 8'h0A;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_TAG    = 4'b0010,
		MODE_ENTITY = 4'b0100,
		MODE_SPACES = 4'b1000
	} mode_t;

	typedef logic [TagKeep-1:0][7:0] tag_chars_t;
	typedef logic [EntKeep-1:0][7:0] ent_chars_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic [31:0] off;
		logic        last;
		logic        ovf;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A);
	endfunction

	// lower case letters to upper case
	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
	endfunction

	// pattern is upper case, first character in the highest used byte
	function automatic logic tag_is(input tag_chars_t tc, input logic [3:0] cnt,
		input logic [55:0] pat, input int len);
		logic ok;
		int   idx;
		ok = (cnt >= 4'(len));
		for (int j = 0; j < 7; j++) begin
			idx = (j < len) ? 8 * (len - 1 - j) : 0;
			if (j < len && fold(tc[3'(j)]) != pat[idx +: 8])
				ok = 1'b0;
		end
		return ok && ((cnt == 4'(len)) || is_ws(tc[3'(len)]));
	endfunction

	// tags that break a block of text
	function automatic logic block_tag_hit(input tag_chars_t tc, input logic [3:0] cnt);
		return tag_is(tc, cnt, "LI", 2)     | tag_is(tc, cnt, "/LI", 3)    |
			tag_is(tc, cnt, "UL", 2)     | tag_is(tc, cnt, "/UL", 3)    |
			tag_is(tc, cnt, "DL", 2)     | tag_is(tc, cnt, "/DL", 3)    |
			tag_is(tc, cnt, "DT", 2)     | tag_is(tc, cnt, "/DT", 3)    |
			tag_is(tc, cnt, "/P", 2)     | tag_is(tc, cnt, "TITLE", 5)  |
			tag_is(tc, cnt, "/TITLE", 6) | tag_is(tc, cnt, "TABLE", 5)  |
			tag_is(tc, cnt, "/TABLE", 6) | tag_is(tc, cnt, "TR", 2)     |
			tag_is(tc, cnt, "/TR", 3)    | tag_is(tc, cnt, "TD", 2)     |
			tag_is(tc, cnt, "/TD", 3)    | tag_is(tc, cnt, "H1", 2)     |
			tag_is(tc, cnt, "/H1", 3)    | tag_is(tc, cnt, "H2", 2)     |
			tag_is(tc, cnt, "/H2", 3)    | tag_is(tc, cnt, "H3", 2)     |
			tag_is(tc, cnt, "/H3", 3);
	endfunction

	// exact, case-sensitive name compare
	function automatic logic ent_is(input ent_chars_t ec, input logic [2:0] cnt,
		input logic [47:0] pat, input int len);
		logic ok;
		int   idx;
		ok = (cnt == 3'(len));
		for (int j = 0; j < 6; j++) begin
			idx = (j < len) ? 8 * (len - 1 - j) : 0;
			if (j < len && ec[3'(j)] != pat[idx +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	// hit flag in the top bit, decoded byte below
	function automatic logic [8:0] ent_decode(input ent_chars_t ec, input logic [2:0] cnt);
		logic [8:0] r;
		r = '0;
		if (ent_is(ec, cnt, "amp", 3))         r = {1'b1, 8'h26};
		else if (ent_is(ec, cnt, "lt", 2))     r = {1'b1, 8'h3C};
		else if (ent_is(ec, cnt, "gt", 2))     r = {1'b1, 8'h3E};
		else if (ent_is(ec, cnt, "nbsp", 4))   r = {1'b1, 8'h20};
		else if (ent_is(ec, cnt, "ouml", 4))   r = {1'b1, 8'hF6};
		else if (ent_is(ec, cnt, "auml", 4))   r = {1'b1, 8'hE4};
		else if (ent_is(ec, cnt, "uuml", 4))   r = {1'b1, 8'hFC};
		else if (ent_is(ec, cnt, "Ouml", 4))   r = {1'b1, 8'hD6};
		else if (ent_is(ec, cnt, "Auml", 4))   r = {1'b1, 8'hC4};
		else if (ent_is(ec, cnt, "Uuml", 4))   r = {1'b1, 8'hDC};
		else if (ent_is(ec, cnt, "szlig", 5))  r = {1'b1, 8'hDF};
		else if (ent_is(ec, cnt, "agrave", 6)) r = {1'b1, 8'hE0};
		else if (ent_is(ec, cnt, "egrave", 6)) r = {1'b1, 8'hE8};
		else if (ent_is(ec, cnt, "eacute", 6)) r = {1'b1, 8'hE9};
		return r;
	endfunction

endpackage

// ===== src/html_markup_text_extractor.sv =====
// html to plain text extractor: one byte in, up to two text bytes out
// depends on hmte_pkg (constants, mode type, tag and entity matchers)
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_ready  | in_byte, doc_last
//  output  | out_valid/out_ready| out_char, src_offset, run_last, nest_overflow
//
// one byte is taken every cycle while the four-entry result queue has room for two
// results; a byte is registered in the input register, then parsed once the queue has
// room, and its results land in the queue, from which the first result is offered.
// a byte that gives two results fills two queue places; the queue depth sets how
// long the output may stall before in_ready drops.
// arst_n clears the parser state and the queue; the nesting stack has no reset and
// is only read below its current depth.
module html_markup_text_extractor #(
	parameter int unsigned NEST_DEPTH = hmte_pkg::NestDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        doc_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic [31:0] src_offset,
	output logic        run_last,
	output logic        nest_overflow
);
	import hmte_pkg::*;

	localparam int unsigned DepW = $clog2(NEST_DEPTH + 1);
	localparam int unsigned IdxW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       go;

	// parser state
	mode_t          mode_q, mode_d;
	tag_chars_t     tchars_q, tchars_d;
	logic [3:0]     tcnt_q, tcnt_d;
	logic           tlead_q, tlead_d;
	ent_chars_t     echars_q, echars_d;
	logic [2:0]     ecnt_q, ecnt_d;
	logic [DepW-1:0] depth_q, depth_d;
	logic [31:0]    bpos_q, mstart_q, mstart_d;
	logic           ovf_q;
	logic           top_q;

	// suppression stack: kind 1 for script, 0 for xml
	logic stack_mem [NEST_DEPTH];

	// result queue
	res_t       q_mem [OutDepth];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop_o;

	// per-byte decode
	logic       ws_c, depth_zero;
	logic       nrm_emit, nrm_tag, nrm_ent;
	logic [7:0] nrm_char;
	mode_t      nrm_mode;
	logic       br_hit, xml_hit, script_hit, close_hit, blk_hit;
	logic [8:0] ent_res;
	logic       push, push_kind, push_ok, pop, ovf_set, again;
	logic [1:0] n_res;
	logic [7:0] rc [2];
	logic [31:0] ro [2];
	logic [DepW-1:0] dm1;
	res_t       r0, r1;

	assign go       = v_s1 && (cnt_q <= 3'd2);
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= doc_last;
		end
	end

	assign ws_c       = is_ws(byte_s1);
	assign depth_zero = (depth_q == '0);

	// tag and entity matchers against the stored name
	assign br_hit     = tag_is(tchars_q, tcnt_q, "BR", 2);
	assign xml_hit    = tag_is(tchars_q, tcnt_q, "XML", 3);
	assign script_hit = tag_is(tchars_q, tcnt_q, "SCRIPT", 6);
	assign close_hit  = top_q ? tag_is(tchars_q, tcnt_q, "/SCRIPT", 7)
		: tag_is(tchars_q, tcnt_q, "/XML", 4);
	assign blk_hit    = block_tag_hit(tchars_q, tcnt_q);
	assign ent_res    = ent_decode(echars_q, ecnt_q);

	// what a byte does in normal mode, used first-hand and for a re-read byte
	always_comb begin
		nrm_emit = 1'b0;
		nrm_char = byte_s1;
		nrm_mode = MODE_NORMAL;
		nrm_tag  = 1'b0;
		nrm_ent  = 1'b0;
		if (ws_c) begin
			nrm_emit = depth_zero;
			nrm_char = ChSpace;
			nrm_mode = MODE_SPACES;
		end else if (byte_s1 == ChLt) begin
			nrm_mode = MODE_TAG;
			nrm_tag  = 1'b1;
		end else if (byte_s1 == ChAmp) begin
			nrm_mode = MODE_ENTITY;
			nrm_ent  = 1'b1;
		end else begin
			nrm_emit = depth_zero;
		end
	end

	// main step
	always_comb begin
		mode_d    = mode_q;
		tchars_d  = tchars_q;
		tcnt_d    = tcnt_q;
		tlead_d   = tlead_q;
		echars_d  = echars_q;
		ecnt_d    = ecnt_q;
		mstart_d  = mstart_q;
		push      = 1'b0;
		push_kind = 1'b0;
		pop       = 1'b0;
		again     = 1'b0;
		n_res     = 2'd0;
		rc[0]     = '0;
		rc[1]     = '0;
		ro[0]     = '0;
		ro[1]     = '0;

		case (mode_q)
			MODE_NORMAL: begin
				if (nrm_emit) begin
					rc[0] = nrm_char;
					ro[0] = bpos_q;
					n_res = 2'd1;
				end
				mode_d = nrm_mode;
				if (nrm_tag) begin
					mstart_d = bpos_q;
					tcnt_d   = '0;
					tlead_d  = 1'b0;
				end
				if (nrm_ent) begin
					mstart_d = bpos_q;
					ecnt_d   = '0;
				end
			end
			MODE_TAG: begin
				if (byte_s1 == ChGt) begin
					mode_d = MODE_NORMAL;
					if (br_hit) begin
						if (depth_zero) begin
							rc[0] = ChNewline;
							ro[0] = mstart_q;
							n_res = 2'd1;
						end
						mode_d = MODE_SPACES;
					end else if (xml_hit) begin
						push = 1'b1;
					end else if (script_hit) begin
						push      = 1'b1;
						push_kind = 1'b1;
					end else if (!depth_zero && close_hit) begin
						pop = 1'b1;
					end else if (blk_hit) begin
						if (depth_zero) begin
							rc[0] = ChNewline;
							ro[0] = mstart_q;
							rc[1] = ChNewline;
							ro[1] = bpos_q;
							n_res = 2'd2;
						end
						mode_d = MODE_SPACES;
					end
				end else if (tlead_q || !ws_c) begin
					// leading whitespace of the tag is skipped
					tlead_d = 1'b1;
					if (tcnt_q < 4'(TagKeep)) begin
						tchars_d[tcnt_q[2:0]] = byte_s1;
						tcnt_d = tcnt_q + 4'd1;
					end
				end
			end
			MODE_ENTITY: begin
				if (is_alnum(byte_s1)) begin
					if (ecnt_q < 3'(EntKeep))
						echars_d[ecnt_q] = byte_s1;
					if (ecnt_q < EntLong)
						ecnt_d = ecnt_q + 3'd1;
				end else begin
					again  = (byte_s1 != ChSemi);
					mode_d = MODE_NORMAL;
					if (depth_zero && ent_res[8]) begin
						rc[0] = ent_res[7:0];
						ro[0] = mstart_q;
						n_res = 2'd1;
					end
				end
			end
			MODE_SPACES: begin
				if (!ws_c) begin
					mode_d = MODE_NORMAL;
					again  = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase

		// a byte ending a space run or a ';'-less entity is read again, unless it ends the document
		if (again && !last_s1) begin
			if (nrm_emit) begin
				rc[n_res[0]] = nrm_char;
				ro[n_res[0]] = bpos_q;
				n_res = n_res + 2'd1;
			end
			mode_d = nrm_mode;
			if (nrm_tag) begin
				mstart_d = bpos_q;
				tcnt_d   = '0;
				tlead_d  = 1'b0;
			end
			if (nrm_ent) begin
				mstart_d = bpos_q;
				ecnt_d   = '0;
			end
		end
	end

	// stack push saturates at the full depth and raises the sticky flag
	assign push_ok = push && (depth_q != DepW'(NEST_DEPTH));
	assign ovf_set = push && !push_ok;
	assign depth_d = push_ok ? depth_q + 1'b1 : (pop ? depth_q - 1'b1 : depth_q);
	assign dm1     = depth_d - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			tcnt_q   <= '0;
			tlead_q  <= 1'b0;
			ecnt_q   <= '0;
			depth_q  <= '0;
			bpos_q   <= '0;
			mstart_q <= '0;
			ovf_q    <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				// end of document: back to the reset state
				mode_q   <= MODE_NORMAL;
				tcnt_q   <= '0;
				tlead_q  <= 1'b0;
				ecnt_q   <= '0;
				depth_q  <= '0;
				bpos_q   <= '0;
				mstart_q <= '0;
				ovf_q    <= 1'b0;
			end else begin
				mode_q   <= mode_d;
				tcnt_q   <= tcnt_d;
				tlead_q  <= tlead_d;
				ecnt_q   <= ecnt_d;
				depth_q  <= depth_d;
				bpos_q   <= bpos_q + 32'd1;
				mstart_q <= mstart_d;
				ovf_q    <= ovf_q | ovf_set;
			end
		end
	end

	// name buffers, only read below their counts
	always_ff @(posedge clk) begin
		if (go) begin
			tchars_q <= tchars_d;
			echars_q <= echars_d;
		end
	end

	// stack memory with a registered top-of-stack read, push value bypassed
	always_ff @(posedge clk) begin
		if (go) begin
			if (push_ok)
				stack_mem[depth_q[IdxW-1:0]] <= push_kind;
			if (push_ok)
				top_q <= push_kind;
			else
				top_q <= stack_mem[dm1[IdxW-1:0]];
		end
	end

	// results of this byte; the flag shows the state after this byte
	always_comb begin
		r0.ch   = rc[0];
		r0.off  = ro[0];
		r0.last = (n_res == 2'd1);
		r0.ovf  = ovf_q | ovf_set;
		r1.ch   = rc[1];
		r1.off  = ro[1];
		r1.last = 1'b1;
		r1.ovf  = ovf_q | ovf_set;
	end

	assign out_valid = (cnt_q != 3'd0);
	assign pop_o     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (go && n_res != 2'd0)
			q_mem[wp_q] <= r0;
		if (go && n_res == 2'd2)
			q_mem[wp_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + (go ? n_res : 2'd0);
			rp_q  <= rp_q + {1'b0, pop_o};
			cnt_q <= cnt_q + (go ? {1'b0, n_res} : 3'd0) - {2'b0, pop_o};
		end
	end

	assign out_char      = q_mem[rp_q].ch;
	assign src_offset    = q_mem[rp_q].off;
	assign run_last      = q_mem[rp_q].last;
	assign nest_overflow = q_mem[rp_q].ovf;

	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(OutDepth))
		else $error("result queue over its depth");

	// stack depth saturates at the configured nesting depth
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepW'(NEST_DEPTH))
		else $error("suppression depth beyond the stack");

	// the last byte of a document leaves the parser in its reset state
	a_doc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> (depth_q == '0) && (bpos_q == '0) && (mode_q == MODE_NORMAL)
			&& !ovf_q)
		else $error("state not cleared after end of document");

	// a byte is only parsed when two queue places are free
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		go && (n_res == 2'd2) |=> cnt_q >= 3'd1)
		else $error("two results lost from the queue");

endmodule

// ===== verif/html_markup_text_extractor_chk.sv =====
// checker for the html text extractor: predicts text items from the accepted bytes
// and compares them, field by field, with the items leaving the output channel
// depends on hmte_pkg (mode type, character constants, result item layout)
module html_markup_text_extractor_chk #(
	parameter int unsigned NEST_DEPTH = hmte_pkg::NestDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        doc_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_char,
	input  logic [31:0] src_offset,
	input  logic        run_last,
	input  logic        nest_overflow,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned texts_checked,
	output int unsigned docs_parsed,
	output int unsigned overflow_docs
);
	import hmte_pkg::*;

	string block_names [23] = '{
		"li", "/li", "ul", "/ul", "dl", "/dl", "dt", "/dt", "/p",
		"title", "/title", "table", "/table", "tr", "/tr", "td", "/td",
		"h1", "/h1", "h2", "/h2", "h3", "/h3"
	};
	string ent_names [14] = '{
		"amp", "lt", "gt", "nbsp", "ouml", "auml", "uuml", "Ouml", "Auml",
		"Uuml", "szlig", "agrave", "egrave", "eacute"
	};
	logic [7:0] ent_codes [14] = '{
		8'h26, 8'h3C, 8'h3E, 8'h20, 8'hF6, 8'hE4, 8'hFC, 8'hD6, 8'hC4,
		8'hDC, 8'hDF, 8'hE0, 8'hE8, 8'hE9
	};

	// parser state as the block should hold it
	mode_t           scan_mode;
	logic [7:0]      tag_buf [TagKeep];
	logic [3:0]      tag_len;
	logic            tag_started;
	logic [7:0]      ent_buf [EntKeep];
	logic [2:0]      ent_len;
	logic            nest_kind [NEST_DEPTH];
	int unsigned     nest_level;
	logic [31:0]     byte_pos;
	logic [31:0]     mark_pos;
	logic            ovf_seen;

	// text made by the byte in hand, then the queue of text items still due
	logic [7:0]      step_ch [2];
	logic [31:0]     step_off [2];
	int              n_text;
	res_t            text_due [$];

	function automatic logic is_blank(input logic [7:0] c);
		return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// tag names compare without case; a blank may follow the name
	function automatic logic tag_named(input string pat);
		int n;
		n = pat.len();
		if (tag_len < n)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (upcase(tag_buf[i]) != upcase(pat[i]))
				return 1'b0;
		if (tag_len == n)
			return 1'b1;
		return is_blank(tag_buf[n]);
	endfunction

	function automatic logic ent_named(input string pat);
		if (pat.len() != ent_len)
			return 1'b0;
		for (int i = 0; i < pat.len(); i++)
			if (ent_buf[i] != pat[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic add_text(input logic [7:0] c, input logic [31:0] off);
		if (n_text < 2) begin
			step_ch[n_text] = c;
			step_off[n_text] = off;
			n_text++;
		end
	endtask

	task automatic push_nest(input logic kind);
		if (nest_level < NEST_DEPTH) begin
			nest_kind[nest_level] = kind;
			nest_level++;
		end else
			ovf_seen = 1'b1;
	endtask

	task automatic clear_doc();
		scan_mode = MODE_NORMAL;
		tag_len = '0;
		tag_started = 1'b0;
		ent_len = '0;
		nest_level = 0;
		byte_pos = '0;
		mark_pos = '0;
		ovf_seen = 1'b0;
	endtask

	task automatic plain_byte(input logic [7:0] c, input logic [31:0] here);
		if (is_blank(c)) begin
			if (nest_level == 0)
				add_text(ChSpace, here);
			scan_mode = MODE_SPACES;
		end else if (c == ChLt) begin
			scan_mode = MODE_TAG;
			mark_pos = here;
			tag_len = '0;
			tag_started = 1'b0;
		end else if (c == ChAmp) begin
			scan_mode = MODE_ENTITY;
			mark_pos = here;
			ent_len = '0;
		end else if (nest_level == 0)
			add_text(c, here);
	endtask

	task automatic close_tag(input logic [31:0] here);
		logic closing;
		logic hit;
		closing = 1'b0;
		hit = 1'b0;
		scan_mode = MODE_NORMAL;
		if (tag_named("br")) begin
			if (nest_level == 0)
				add_text(ChNewline, mark_pos);
			scan_mode = MODE_SPACES;
		end else if (tag_named("xml"))
			push_nest(1'b0);
		else if (tag_named("script"))
			push_nest(1'b1);
		else begin
			// only the kind on top of the stack closes a section
			if (nest_level > 0) begin
				if (nest_kind[nest_level - 1])
					closing = tag_named("/script");
				else
					closing = tag_named("/xml");
			end
			if (closing)
				nest_level--;
			else begin
				for (int i = 0; i < 23; i++)
					if (tag_named(block_names[i]))
						hit = 1'b1;
				if (hit) begin
					if (nest_level == 0) begin
						add_text(ChNewline, mark_pos);
						add_text(ChNewline, here);
					end
					scan_mode = MODE_SPACES;
				end
			end
		end
	endtask

	task automatic close_entity();
		logic found;
		found = 1'b0;
		if (nest_level == 0)
			for (int i = 0; i < 14; i++)
				if (!found && ent_named(ent_names[i])) begin
					add_text(ent_codes[i], mark_pos);
					found = 1'b1;
				end
		scan_mode = MODE_NORMAL;
	endtask

	// works out the text items caused by one accepted byte
	task automatic predict_text(input logic [7:0] c, input logic fin);
		logic [31:0]    here;
		logic           again;
		res_t           item;
		here = byte_pos;
		byte_pos = byte_pos + 32'd1;
		again = 1'b0;
		n_text = 0;
		case (scan_mode)
		MODE_NORMAL: plain_byte(c, here);
		MODE_TAG: begin
			if (c == ChGt)
				close_tag(here);
			else if (tag_started || !is_blank(c)) begin
				tag_started = 1'b1;
				if (tag_len < TagKeep) begin
					tag_buf[tag_len] = c;
					tag_len++;
				end
			end
		end
		MODE_ENTITY: begin
			if (is_word(c)) begin
				if (ent_len < EntKeep)
					ent_buf[ent_len] = c;
				if (ent_len < EntLong)
					ent_len++;
			end else begin
				again = (c != ChSemi);
				close_entity();
			end
		end
		default: begin
			if (!is_blank(c)) begin
				scan_mode = MODE_NORMAL;
				again = 1'b1;
			end
		end
		endcase
		// the byte that ends a run, or ends an entity other than by ';', is parsed again, unless it ends the document
		if (again && !fin)
			plain_byte(c, here);
		for (int k = 0; k < n_text; k++) begin
			item.ch = step_ch[k];
			item.off = step_off[k];
			item.last = (k == n_text - 1);
			item.ovf = ovf_seen;
			text_due = {text_due, item};
		end
		if (fin) begin
			docs_parsed++;
			if (ovf_seen)
				overflow_docs++;
			clear_doc();
		end
	endtask

	task automatic field_diff(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	task automatic check_text();
		res_t want;
		if (text_due.size() == 0) begin
			$display("%0t: text item %h at offset %h with none expected, expected nothing got %h",
				$time, out_char, src_offset, out_char);
			mismatches++;
		end else begin
			want = text_due.pop_front();
			texts_checked++;
			field_diff("out_char", 32'(want.ch), 32'(out_char));
			field_diff("src_offset", want.off, src_offset);
			field_diff("run_last", 32'(want.last), 32'(run_last));
			field_diff("nest_overflow", 32'(want.ovf), 32'(nest_overflow));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_doc();
			text_due.delete();
			mismatches = 0;
			texts_checked = 0;
			docs_parsed = 0;
			overflow_docs = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_text(in_byte, doc_last);
			if (out_valid && out_ready)
				check_text();
			outstanding <= text_due.size();
		end
	end

endmodule

// ===== verif/html_markup_text_extractor_tb.sv =====
// testbench top for the html text extractor: makes the byte stream, drives both
// handshakes and gives the verdict; checking lives in html_markup_text_extractor_chk
// depends on hmte_pkg, html_markup_text_extractor and html_markup_text_extractor_chk
module html_markup_text_extractor_tb;
	import hmte_pkg::*;

	localparam int unsigned RandomBytes = 770;
	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned StallLimit  = 4000;
	localparam int unsigned DrainCycles = 16;

	// ways the output side takes items
	typedef enum int {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SLOW,
		DRAIN_BEAT,
		DRAIN_HOLD
	} drain_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        doc_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_char;
	logic [31:0] src_offset;
	logic        run_last;
	logic        nest_overflow;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned texts_checked;
	int unsigned docs_parsed;
	int unsigned overflow_docs;

	// bytes of the document being built, and sender bookkeeping
	logic [7:0]  doc_bytes [$];
	int unsigned bytes_sent = 0;
	int          burst_left = 0;

	// markup vocabulary: nesting tags are kept apart so they can be weighted down
	string nest_words [4] = '{"xml", "script", "/xml", "/script"};
	string tag_words [] = '{
		"br", "li", "/li", "ul", "/ul", "dl", "/dl", "dt", "/dt", "/p",
		"title", "/title", "table", "/table", "tr", "/tr", "td", "/td",
		"h1", "/h1", "h2", "/h2", "h3", "/h3", "p", "div", "b", "brr", "/br",
		"scripts", "xmlns"
	};
	string ent_words [] = '{
		"amp", "lt", "gt", "nbsp", "ouml", "auml", "uuml", "Ouml", "Auml",
		"Uuml", "szlig", "agrave", "egrave", "eacute", "AMP", "ltx", "eacutes", "q"
	};
	string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
	// bytes other than ';' that end an entity name
	string stop_set = " <&.";

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	html_markup_text_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.doc_last      (doc_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.src_offset    (src_offset),
		.run_last      (run_last),
		.nest_overflow (nest_overflow)
	);

	html_markup_text_extractor_chk scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.doc_last      (doc_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.src_offset    (src_offset),
		.run_last      (run_last),
		.nest_overflow (nest_overflow),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.texts_checked (texts_checked),
		.docs_parsed   (docs_parsed),
		.overflow_docs (overflow_docs)
	);

	// flip the case of a letter half of the time, tag names match either way
	function automatic logic [7:0] jumble(input logic [7:0] c);
		if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1) == 1)
			return c ^ 8'h20;
		return c;
	endfunction

	// one of the six whitespace bytes
	function automatic logic [7:0] any_blank();
		int pick;
		pick = $urandom_range(0, 5);
		return (pick == 5) ? ChSpace : 8'(8'h09 + pick);
	endfunction

	// add one byte to the end of the document being built
	task automatic append_byte(input logic [7:0] b);
		doc_bytes = {doc_bytes, b};
	endtask

	task automatic put_text(input string s, input logic mix);
		for (int i = 0; i < s.len(); i++)
			append_byte(mix ? jumble(s[i]) : s[i]);
	endtask

	// offer one item and hold it until taken; bursts keep valid high between items,
	// and a burst ends in a gap of random length, sometimes none
	task automatic offer(input logic [7:0] b, input logic fin);
		int gap;
		in_valid <= 1'b1;
		in_byte <= b;
		doc_last <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// send the built document, flagging its last byte, then start a fresh one
	task automatic ship_doc();
		for (int i = 0; i < doc_bytes.size(); i++)
			offer(doc_bytes[i], i == doc_bytes.size() - 1);
		doc_bytes.delete();
	endtask

	// a random document: mostly well-formed text, tags and entities, some raw noise;
	// now and then a deep pile of xml and script sections to run the stack over
	task automatic build_doc();
		int    pick;
		string word;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(12, 20)) begin
				if ($urandom_range(0, 1) == 1)
					put_text("<xml>", 1'b1);
				else
					put_text("<script >", 1'b1);
			end
			put_text("hid &amp; den", 1'b0);
			repeat ($urandom_range(0, 20)) begin
				if ($urandom_range(0, 1) == 1)
					put_text("</xml>", 1'b1);
				else
					put_text("</script>", 1'b1);
			end
			put_text("tail<br>", 1'b0);
		end else begin
			repeat ($urandom_range(3, 30)) begin
				pick = $urandom_range(0, 19);
				if (pick < 5) begin
					// printable text, now and then starting stray markup
					repeat ($urandom_range(1, 4))
						append_byte(8'($urandom_range(8'h21, 8'h7E)));
				end else if (pick < 7) begin
					repeat ($urandom_range(1, 3))
						append_byte(any_blank());
				end else if (pick < 13) begin
					append_byte(ChLt);
					if ($urandom_range(0, 3) == 0)
						append_byte(any_blank());
					if ($urandom_range(0, 7) == 0)
						word = nest_words[$urandom_range(0, 3)];
					else
						word = tag_words[$urandom_range(0, tag_words.size() - 1)];
					put_text(word, 1'b1);
					// an attribute makes the name run past the kept length
					if ($urandom_range(0, 3) == 0) begin
						append_byte(any_blank());
						put_text("class=x", 1'b1);
					end
					append_byte(ChGt);
				end else if (pick < 17) begin
					append_byte(ChAmp);
					if ($urandom_range(0, 2) != 0)
						put_text(ent_words[$urandom_range(0, ent_words.size() - 1)], 1'b0);
					else
						repeat ($urandom_range(1, 8))
							append_byte(alnum_set[$urandom_range(0, 61)]);
					if ($urandom_range(0, 3) != 0)
						append_byte(ChSemi);
					else
						append_byte(stop_set[$urandom_range(0, 3)]);
				end else
					append_byte(8'($urandom_range(0, 255)));
			end
			// cut the tail now and then so markup is left open at document end
			if ($urandom_range(0, 7) == 0 && doc_bytes.size() > 3)
				repeat ($urandom_range(1, 2))
					void'(doc_bytes.pop_back());
		end
	endtask

	// output side: segments of different stall patterns, the fourth one a long
	// hold-off so the result queue fills and the input side has to stall
	initial begin : drain
		int           seg;
		int           span;
		drain_style_t style;
		seg = 0;
		forever begin
			if (seg == 3) begin
				span = HoldCycles;
				style = DRAIN_HOLD;
			end else begin
				span = $urandom_range(10, 80);
				style = drain_style_t'($urandom_range(0, 3));
			end
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (style)
				DRAIN_FREE: out_ready <= 1'b1;
				DRAIN_COIN: out_ready <= 1'($urandom_range(0, 1));
				DRAIN_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
				DRAIN_BEAT: out_ready <= (i % 3 != 0);
				default:    out_ready <= 1'b0;
				endcase
			end
			seg++;
		end
	end

	// ends the run when no item has moved on either channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no item moved for %0d cycles, %0d text items still due",
			StallLimit, outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme byte values, a whitespace run ended by a byte that is parsed again,
		// and an entity ended by a non-semicolon on the last byte, which is dropped
		append_byte(8'h00);
		put_text("  ", 1'b0);
		append_byte(8'hFF);
		put_text("&lt.", 1'b0);
		ship_doc();
		// suppressed section in mixed case, a line break and a block tag at the end
		put_text("<XmL>q</xml><Br><li>", 1'b0);
		ship_doc();
		// longest entity name
		put_text("&eacute;", 1'b0);
		ship_doc();

		while (bytes_sent < RandomBytes) begin
			build_doc();
			ship_doc();
		end
		in_valid <= 1'b0;

		// wait so the last item's expectations are counted, then drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DrainCycles)
			@(posedge clk);

		$display("summary: %0d bytes in %0d documents, %0d text items compared",
			bytes_sent, docs_parsed, texts_checked);
		$display("summary: %0d documents ran the nesting stack over, one %0d-cycle output stall",
			overflow_docs, HoldCycles);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
src/hmte_pkg.sv
src/html_markup_text_extractor.sv
verif/html_markup_text_extractor_chk.sv
verif/html_markup_text_extractor_tb.sv
